[src/scl_pkg.sv]
`timescale 1ns / 1ps

package scl_pkg;

  // fixed point one in q1.14
  localparam int unsigned ONE_Q14 = 16384;

  // payload widths
  localparam int unsigned VEC_W    = 16;
  localparam int unsigned WEIGHT_W = 15;
  localparam int unsigned CFG_IDX_W = 3;

  // pipeline widths
  localparam int unsigned SQ_W   = 32;   // sum of three squares
  localparam int unsigned DOT_W  = 33;   // signed dot product
  localparam int unsigned PROD_W = 64;   // |dir|^2 * |axis|^2
  localparam int unsigned ROOT_W = 32;   // isqrt of the product
  localparam int unsigned Q_W    = 15;   // quotient bits of both dividers
  localparam int unsigned DIV1_NW = 48;
  localparam int unsigned DIV1_DW = 33;
  localparam int unsigned DIV2_NW = 32;
  localparam int unsigned DIV2_DW = 17;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_X       = 3'd0,
    CFG_AXIS_Y       = 3'd1,
    CFG_AXIS_Z       = 3'd2,
    CFG_COS_CONE     = 3'd3,
    CFG_COS_PENUMBRA = 3'd4
  } cfg_idx_t;

  // reset values of the registers
  localparam logic signed [VEC_W-1:0] RST_AXIS_X   = 16'sd0;
  localparam logic signed [VEC_W-1:0] RST_AXIS_Y   = 16'sd0;
  localparam logic signed [VEC_W-1:0] RST_AXIS_Z   = -16'sd16384;
  localparam logic signed [VEC_W-1:0] RST_COS_CONE = 16'sd14189;
  localparam logic signed [VEC_W-1:0] RST_COS_PEN  = 16'sd15826;

  // weight class after the cone tests
  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_FULL = 2'd1,
    CLS_MID  = 2'd2
  } cls_t;

  // pipeline control handed to each sub-unit
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

[src/scl_isqrt.sv]
`timescale 1ns / 1ps

// pipelined integer square root, one result bit per stage
module scl_isqrt #(
  parameter int unsigned XW = scl_pkg::PROD_W,
  parameter int unsigned SW = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  scl_pkg::pipe_ctl_t      ctl_in,
  input  logic [XW-1:0]           x_in,
  input  logic [SW-1:0]           side_in,
  output logic                    valid_out,
  output logic [XW/2-1:0]         root_out,
  output logic [SW-1:0]           side_out
);

  localparam int unsigned NST = XW / 2;

  logic          vld_r  [NST+1];
  logic [XW-1:0] x_r    [NST+1];
  logic [XW-1:0] res_r  [NST+1];
  logic [SW-1:0] side_r [NST+1];

  // stage zero is the input
  always_comb begin
    vld_r[0]  = ctl_in.valid;
    x_r[0]    = x_in;
    res_r[0]  = '0;
    side_r[0] = side_in;
  end

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_st
      localparam int unsigned SH = XW - 2 - 2 * k;
      logic [XW-1:0] bit_c;
      logic [XW-1:0] trial;
      logic [XW-1:0] x_nxt;
      logic [XW-1:0] res_nxt;

      // one digit of the root
      always_comb begin
        bit_c = XW'(1) << SH;
        trial = res_r[k] + bit_c;
        if (x_r[k] >= trial) begin
          x_nxt   = x_r[k] - trial;
          res_nxt = (res_r[k] >> 1) + bit_c;
        end else begin
          x_nxt   = x_r[k];
          res_nxt = res_r[k] >> 1;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k+1] <= 1'b0;
        end else if (ctl_in.en) begin
          vld_r[k+1] <= vld_r[k];
        end
      end

      always_ff @(posedge clk) begin
        if (ctl_in.en) begin
          x_r[k+1]    <= x_nxt;
          res_r[k+1]  <= res_nxt;
          side_r[k+1] <= side_r[k];
        end
      end
    end
  endgenerate

  assign valid_out = vld_r[NST];
  assign root_out  = res_r[NST][XW/2-1:0];
  assign side_out  = side_r[NST];

endmodule

[src/scl_div.sv]
`timescale 1ns / 1ps

// pipelined restoring divider, one quotient bit per stage
module scl_div #(
  parameter int unsigned NW = scl_pkg::DIV1_NW,
  parameter int unsigned DW = scl_pkg::DIV1_DW,
  parameter int unsigned QW = scl_pkg::Q_W,
  parameter int unsigned SW = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  scl_pkg::pipe_ctl_t ctl_in,
  input  logic [NW-1:0]      num_in,
  input  logic [DW-1:0]      den_in,
  input  logic [SW-1:0]      side_in,
  output logic               valid_out,
  output logic [QW-1:0]      quo_out,
  output logic [SW-1:0]      side_out
);

  localparam int unsigned CW = NW + DW + QW;

  logic          vld_r  [QW+1];
  logic [NW-1:0] rem_r  [QW+1];
  logic [DW-1:0] den_r  [QW+1];
  logic [QW-1:0] quo_r  [QW+1];
  logic [SW-1:0] side_r [QW+1];

  always_comb begin
    vld_r[0]  = ctl_in.valid;
    rem_r[0]  = num_in;
    den_r[0]  = den_in;
    quo_r[0]  = '0;
    side_r[0] = side_in;
  end

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_st
      localparam int unsigned SH = QW - 1 - k;
      logic [CW-1:0] rem_ext;
      logic [CW-1:0] dsh;
      logic [NW-1:0] rem_nxt;
      logic [QW-1:0] quo_nxt;

      // compare and subtract the shifted divisor
      always_comb begin
        rem_ext = CW'(rem_r[k]);
        dsh     = CW'(den_r[k]) << SH;
        if (rem_ext >= dsh) begin
          rem_nxt = NW'(rem_ext - dsh);
          quo_nxt = quo_r[k] | (QW'(1) << SH);
        end else begin
          rem_nxt = rem_r[k];
          quo_nxt = quo_r[k];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k+1] <= 1'b0;
        end else if (ctl_in.en) begin
          vld_r[k+1] <= vld_r[k];
        end
      end

      always_ff @(posedge clk) begin
        if (ctl_in.en) begin
          rem_r[k+1]  <= rem_nxt;
          den_r[k+1]  <= den_r[k];
          quo_r[k+1]  <= quo_nxt;
          side_r[k+1] <= side_r[k];
        end
      end
    end
  endgenerate

  assign valid_out = vld_r[QW];
  assign quo_out   = quo_r[QW];
  assign side_out  = side_r[QW];

endmodule

[src/spotlight_cone_falloff_core.sv]
`timescale 1ns / 1ps
// spotlight cone falloff, fully pipelined
// throughput: one item per cycle; the 32-stage square root and two 15-stage
// dividers set the depth, the whole pipe holds while out_stall keeps a result
// reset: synchronous active-low rst_n empties the pipe and loads the axis and
// cone registers with their defaults
module spotlight_cone_falloff_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [scl_pkg::VEC_W-1:0]  in_dir_x,
  input  logic signed [scl_pkg::VEC_W-1:0]  in_dir_y,
  input  logic signed [scl_pkg::VEC_W-1:0]  in_dir_z,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [scl_pkg::WEIGHT_W-1:0]      out_weight,
  output logic                              out_degenerate,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scl_pkg::VEC_W-1:0]         cfg_data
);

  localparam int unsigned VW  = scl_pkg::VEC_W;
  localparam int unsigned SQW = scl_pkg::SQ_W;
  localparam int unsigned DTW = scl_pkg::DOT_W;
  localparam int unsigned PW  = scl_pkg::PROD_W;
  localparam int unsigned RW  = scl_pkg::ROOT_W;
  localparam int unsigned QW  = scl_pkg::Q_W;
  localparam int unsigned N1  = scl_pkg::DIV1_NW;
  localparam int unsigned D1  = scl_pkg::DIV1_DW;
  localparam int unsigned N2  = scl_pkg::DIV2_NW;
  localparam int unsigned D2  = scl_pkg::DIV2_DW;
  localparam int unsigned WW  = scl_pkg::WEIGHT_W;
  localparam int unsigned S1W = 2 + SQW;   // degenerate, sign, |dot|
  localparam int unsigned S2W = 3;         // degenerate, class

  logic en;
  scl_pkg::pipe_ctl_t ctl_c [3];

  // configuration registers
  logic signed [VW-1:0] axis_x_r, axis_y_r, axis_z_r, cone_r, pen_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_x_r <= scl_pkg::RST_AXIS_X;
      axis_y_r <= scl_pkg::RST_AXIS_Y;
      axis_z_r <= scl_pkg::RST_AXIS_Z;
      cone_r   <= scl_pkg::RST_COS_CONE;
      pen_r    <= scl_pkg::RST_COS_PEN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        scl_pkg::CFG_AXIS_X:       axis_x_r <= cfg_data;
        scl_pkg::CFG_AXIS_Y:       axis_y_r <= cfg_data;
        scl_pkg::CFG_AXIS_Z:       axis_z_r <= cfg_data;
        scl_pkg::CFG_COS_CONE:     cone_r   <= cfg_data;
        scl_pkg::CFG_COS_PENUMBRA: pen_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipe advances unless a finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: products
  logic                  v1_r;
  logic signed [2*VW-1:0] vxx_r, vyy_r, vzz_r, axx_r, ayy_r, azz_r, dx_r, dy_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vxx_r <= in_dir_x * in_dir_x;
      vyy_r <= in_dir_y * in_dir_y;
      vzz_r <= in_dir_z * in_dir_z;
      axx_r <= axis_x_r * axis_x_r;
      ayy_r <= axis_y_r * axis_y_r;
      azz_r <= axis_z_r * axis_z_r;
      dx_r  <= in_dir_x * axis_x_r;
      dy_r  <= in_dir_y * axis_y_r;
      dz_r  <= in_dir_z * axis_z_r;
    end
  end

  // stage 2: lengths and dot product
  logic                  v2_r;
  logic [SQW-1:0]        lv_r, la_r;
  logic signed [DTW-1:0] dot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lv_r  <= SQW'(vxx_r) + SQW'(vyy_r) + SQW'(vzz_r);
      la_r  <= SQW'(axx_r) + SQW'(ayy_r) + SQW'(azz_r);
      dot_r <= DTW'(dx_r) + DTW'(dy_r) + DTW'(dz_r);
    end
  end

  // stage 3: length product, |dot|, degenerate flag
  logic           v3_r;
  logic [PW-1:0]  p_r;
  logic [SQW-1:0] ad_r;
  logic           neg3_r, deg3_r;
  logic [DTW-1:0] dot_abs;

  assign dot_abs = dot_r[DTW-1] ? DTW'(-dot_r) : DTW'(dot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= PW'(lv_r) * PW'(la_r);
      ad_r   <= dot_abs[SQW-1:0];
      neg3_r <= dot_r[DTW-1];
      deg3_r <= (lv_r == '0) || (la_r == '0);
    end
  end

  // square root of the length product
  logic           v4;
  logic [RW-1:0]  root;
  logic [S1W-1:0] side4;

  assign ctl_c[0] = '{en: en, valid: v3_r};

  scl_isqrt #(
    .XW (PW),
    .SW (S1W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl_c[0]),
    .x_in      (p_r),
    .side_in   ({deg3_r, neg3_r, ad_r}),
    .valid_out (v4),
    .root_out  (root),
    .side_out  (side4)
  );

  // cosine magnitude, rounded
  logic [N1-1:0] num1;
  logic [D1-1:0] den1;
  logic          v5;
  logic [QW-1:0] mag;
  logic [1:0]    side5;

  assign num1 = (N1'(side4[SQW-1:0]) << 15) + N1'(root);
  assign den1 = D1'(root) << 1;
  assign ctl_c[1] = '{en: en, valid: v4};

  scl_div #(
    .NW (N1),
    .DW (D1),
    .QW (QW),
    .SW (2)
  ) u_div_cos (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl_c[1]),
    .num_in    (num1),
    .den_in    (den1),
    .side_in   (side4[S1W-1:S1W-2]),
    .valid_out (v5),
    .quo_out   (mag),
    .side_out  (side5)
  );

  // stage: signed cosine against the cone limits
  logic [QW-1:0]     mag_c;
  logic signed [16:0] cosq, cone_x, pen_x, num_s, span_s;
  scl_pkg::cls_t     cls_c;

  always_comb begin
    mag_c  = (mag > QW'(scl_pkg::ONE_Q14)) ? QW'(scl_pkg::ONE_Q14) : mag;
    cosq   = side5[0] ? -$signed({2'b00, mag_c}) : $signed({2'b00, mag_c});
    cone_x = 17'(cone_r);
    pen_x  = 17'(pen_r);
    num_s  = cosq - cone_x;
    span_s = pen_x - cone_x;
    if (cosq < cone_x) begin
      cls_c = scl_pkg::CLS_ZERO;
    end else if (cosq > pen_x || pen_x == cone_x) begin
      cls_c = scl_pkg::CLS_FULL;
    end else begin
      cls_c = scl_pkg::CLS_MID;
    end
  end

  logic          v6_r, deg6_r;
  scl_pkg::cls_t cls6_r;
  logic [15:0]   num6_r, span6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg6_r  <= side5[1];
      cls6_r  <= cls_c;
      num6_r  <= num_s[15:0];
      span6_r <= span_s[15:0];
    end
  end

  // fraction of the cosine span, rounded
  logic [N2-1:0] num2;
  logic [D2-1:0] den2;
  logic          v7;
  logic [QW-1:0] t_q;
  logic [S2W-1:0] side7;

  assign num2 = (N2'(num6_r) << 15) + N2'(span6_r);
  assign den2 = D2'(span6_r) << 1;
  assign ctl_c[2] = '{en: en, valid: v6_r};

  scl_div #(
    .NW (N2),
    .DW (D2),
    .QW (QW),
    .SW (S2W)
  ) u_div_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl_c[2]),
    .num_in    (num2),
    .den_in    (den2),
    .side_in   ({deg6_r, cls6_r}),
    .valid_out (v7),
    .quo_out   (t_q),
    .side_out  (side7)
  );

  // stage: t squared
  logic          v8_r;
  logic [QW-1:0] t8_r;
  logic [2*QW-1:0] tt8_r;
  logic [S2W-1:0] side8_r;
  logic [QW-1:0] t_c;

  assign t_c = (t_q > QW'(scl_pkg::ONE_Q14)) ? QW'(scl_pkg::ONE_Q14) : t_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t8_r    <= t_c;
      tt8_r   <= (2*QW)'(t_c) * (2*QW)'(t_c);
      side8_r <= side7;
    end
  end

  // stage: times (3 - 2t)
  logic           v9_r;
  logic [45:0]    pr9_r;
  logic [S2W-1:0] side9_r;
  logic [15:0]    m_c;

  assign m_c = 16'(3 * scl_pkg::ONE_Q14) - {t8_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (en) begin
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr9_r   <= 46'(tt8_r) * 46'(m_c);
      side9_r <= side8_r;
    end
  end

  // output register: round, clamp, select by class, zero when degenerate
  logic [45:0]   rnd;
  logic [17:0]   w_full;
  logic [WW-1:0] w_mid, w_nxt;
  scl_pkg::cls_t cls9;
  logic          out_valid_r, out_deg_r;
  logic [WW-1:0] out_weight_r;

  always_comb begin
    rnd    = pr9_r + 46'(1 << 27);
    w_full = rnd[45:28];
    w_mid  = (w_full > 18'(scl_pkg::ONE_Q14)) ? WW'(scl_pkg::ONE_Q14) : w_full[WW-1:0];
    cls9   = scl_pkg::cls_t'(side9_r[1:0]);
    if (side9_r[2]) begin
      w_nxt = '0;
    end else begin
      unique case (cls9)
        scl_pkg::CLS_ZERO: w_nxt = '0;
        scl_pkg::CLS_FULL: w_nxt = WW'(scl_pkg::ONE_Q14);
        scl_pkg::CLS_MID:  w_nxt = w_mid;
        default:           w_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_weight_r <= w_nxt;
      out_deg_r    <= side9_r[2];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_weight     = out_weight_r;
  assign out_degenerate = out_deg_r;

endmodule
